// ----- hdl/swmc_pkg.sv -----
// ----------------------------------------------------------------------------
// swmc_pkg
// Shared widths for the sliding-window median cost block.
// ----------------------------------------------------------------------------
package swmc_pkg;

  localparam int unsigned SAMPLE_PORT_W = 32;
  localparam int unsigned WIN_SIZE_W    = 7;
  localparam int unsigned COST_W        = 38;

  typedef logic [COST_W-1:0]     cost_t;
  typedef logic [WIN_SIZE_W-1:0] win_size_t;

endpackage

// ----- hdl/sliding_window_median_cost_top.sv -----
// ----------------------------------------------------------------------------
// sliding_window_median_cost_top
// Sum of absolute deviations from the lower median over a sliding window.
// ----------------------------------------------------------------------------
// Takes one signed sample per clock while in_ready_o is high. The window is
// held as a row of sorted cells that all update in the cycle a beat is
// accepted, together with a running total and a running sum of the lower
// half; the cost of a full window follows from those without a sum over the
// cells. That cell update sets the rate: one sample per clock while the
// two-entry output queue has room; the cost beat is pushed into it when the
// sample that completes the window is accepted. in_ready_o drops only while
// both queue entries are taken. No result is given until window_size samples
// are held; window_size is written through the cfg channel while the block
// is idle (the user's duty; the block does not enforce it), 0 acts as 1 and
// values above WINDOW_MAX act as WINDOW_MAX. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module sliding_window_median_cost_top #(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  logic [swmc_pkg::WIN_SIZE_W-1:0]             window_size_i,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic signed [swmc_pkg::SAMPLE_PORT_W-1:0]   sample_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic [swmc_pkg::COST_W-1:0]                 cost_o
);

  localparam int unsigned AW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned NW   = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SW   = SAMPLE_BITS + NW + 1;
  localparam int unsigned CW   = (SW > swmc_pkg::COST_W) ? SW : swmc_pkg::COST_W;
  localparam int unsigned CMPW = ((NW > swmc_pkg::WIN_SIZE_W) ? NW : swmc_pkg::WIN_SIZE_W) + 1;

  swmc_pkg::win_size_t            window_size_q;
  logic [NW-1:0]                  fill_q;
  logic [AW-1:0]                  wr_ptr_q;
  logic [AW-1:0]                  old_ptr_q;
  logic [AW-1:0]                  old_ptr_nx;
  logic [AW-1:0]                  rd_addr;
  logic [WINDOW_MAX-1:0]          vld_q;
  logic [WINDOW_MAX-1:0]          msel_q;
  logic [WINDOW_MAX-1:0]          msel_m1;
  logic signed [SW-1:0]           low_sum_q;
  logic signed [SW-1:0]           tot_sum_q;
  logic signed [SAMPLE_BITS-1:0]  sorted_q [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0]  ring_q   [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0]  oldest_q;

  logic signed [SAMPLE_BITS-1:0]  smp;
  logic signed [SAMPLE_BITS-1:0]  old_smp;
  logic signed [SAMPLE_BITS-1:0]  ins_cell [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0]  rem_cell [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0]  upd_cell [WINDOW_MAX];
  logic [WINDOW_MAX:0]            gt_x;
  logic [WINDOW_MAX-1:0]          lt_o;
  logic [WINDOW_MAX-1:0]          gt_rem;

  logic signed [SAMPLE_BITS-1:0]  s_k;
  logic signed [SAMPLE_BITS-1:0]  s_km1;
  logic signed [SAMPLE_BITS-1:0]  a_k;
  logic signed [SAMPLE_BITS-1:0]  a_km1;
  logic                           gt_k;
  logic                           gt_km1;
  logic                           k_nz;
  logic                           n_even;
  logic [CMPW-1:0]                cnt1;
  logic                           emit;
  logic                           in_acc;
  logic signed [SW-1:0]           low_k1;
  logic signed [SW-1:0]           low_k;
  logic signed [SW-1:0]           tot_a;
  logic signed [SW-1:0]           low_sum_d;
  logic signed [SW-1:0]           tot_sum_d;
  logic signed [CW-1:0]           cost_full;

  logic [1:0]                     oc_q;
  swmc_pkg::cost_t                e0_q;
  swmc_pkg::cost_t                e1_q;
  logic                           push;
  logic                           pop;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (oc_q != 2'd2);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (oc_q != 2'd0);
  assign cost_o      = e0_q;

  assign smp     = SAMPLE_BITS'(sample_i);
  assign old_smp = (fill_q == '0) ? smp : oldest_q;
  assign n_even  = !fill_q[0];
  assign k_nz    = !msel_q[0];
  assign msel_m1 = msel_q >> 1;

  assign cnt1 = CMPW'(fill_q) + CMPW'(1);
  assign emit = (window_size_q == '0) || (cnt1 >= CMPW'(window_size_q)) ||
                (cnt1 >= CMPW'(WINDOW_MAX));

  // sorted cells: insert the new sample, and on a full window drop the oldest
  assign gt_x[WINDOW_MAX] = 1'b1;
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] s_up;
    assign gt_x[i] = !vld_q[i] || (sorted_q[i] > smp);
    assign lt_o[i] = vld_q[i] && (sorted_q[i] < old_smp);
    if (i == WINDOW_MAX - 1) begin : g_last
      assign s_up = sorted_q[i];
    end else begin : g_mid
      assign s_up = sorted_q[i+1];
    end
    assign rem_cell[i] = lt_o[i] ? sorted_q[i] : s_up;
    assign gt_rem[i]   = lt_o[i] ? gt_x[i] : gt_x[i+1];
    if (i == 0) begin : g_first
      assign ins_cell[i] = gt_x[i] ? smp : sorted_q[i];
      assign upd_cell[i] = emit ? (gt_rem[i] ? smp : rem_cell[i]) : ins_cell[i];
    end else begin : g_rest
      assign ins_cell[i] = gt_x[i-1] ? sorted_q[i-1] : (gt_x[i] ? smp : sorted_q[i]);
      assign upd_cell[i] = emit ?
                           (gt_rem[i-1] ? rem_cell[i-1] : (gt_rem[i] ? smp : rem_cell[i])) :
                           ins_cell[i];
    end
  end

  always_comb begin
    s_k   = '0;
    s_km1 = '0;
    a_k   = '0;
    a_km1 = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      s_k   = s_k   | (msel_q[i]  ? sorted_q[i] : '0);
      s_km1 = s_km1 | (msel_m1[i] ? sorted_q[i] : '0);
      a_k   = a_k   | (msel_q[i]  ? ins_cell[i] : '0);
      a_km1 = a_km1 | (msel_m1[i] ? ins_cell[i] : '0);
    end
    gt_k   = |(msel_q  & gt_x[WINDOW_MAX-1:0]);
    gt_km1 = |(msel_m1 & gt_x[WINDOW_MAX-1:0]);
  end

  always_comb begin
    low_k1 = low_sum_q + SW'(gt_k ? smp : s_k);
    low_k  = low_sum_q + ((k_nz && gt_km1) ? (SW'(smp) - SW'(s_km1)) : SW'(0));
    tot_a  = tot_sum_q + SW'(smp);
    cost_full = CW'(tot_a) - (CW'(low_k1) <<< 1) + (n_even ? CW'(a_k) : CW'(0));
    if (emit) begin
      low_sum_d = (k_nz && (a_km1 >= old_smp)) ? (low_k1 - SW'(old_smp)) : low_k;
      tot_sum_d = tot_a - SW'(old_smp);
    end else begin
      low_sum_d = n_even ? low_k : low_k1;
      tot_sum_d = tot_a;
    end
  end

  assign old_ptr_nx = (old_ptr_q == AW'(WINDOW_MAX - 1)) ? '0 : old_ptr_q + AW'(1);
  assign rd_addr    = emit ? old_ptr_nx : old_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= swmc_pkg::WIN_SIZE_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      window_size_q <= window_size_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      wr_ptr_q  <= '0;
      old_ptr_q <= '0;
      vld_q     <= '0;
      msel_q    <= WINDOW_MAX'(1);
      low_sum_q <= '0;
      tot_sum_q <= '0;
    end else if (in_acc) begin
      wr_ptr_q  <= (wr_ptr_q == AW'(WINDOW_MAX - 1)) ? '0 : wr_ptr_q + AW'(1);
      low_sum_q <= low_sum_d;
      tot_sum_q <= tot_sum_d;
      if (emit) begin
        old_ptr_q <= old_ptr_nx;
      end else begin
        fill_q <= fill_q + NW'(1);
        vld_q  <= (vld_q << 1) | WINDOW_MAX'(1);
        if (fill_q[0]) begin
          msel_q <= msel_q << 1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ring_q[wr_ptr_q] <= smp;
      oldest_q         <= (rd_addr == wr_ptr_q) ? smp : ring_q[rd_addr];
      for (int i = 0; i < WINDOW_MAX; i++) begin
        sorted_q[i] <= upd_cell[i];
      end
    end
  end

  // two-entry output queue
  assign push = in_acc && emit;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oc_q <= 2'd0;
    end else if (push && !pop) begin
      oc_q <= oc_q + 2'd1;
    end else if (pop && !push) begin
      oc_q <= oc_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && pop) begin
      if (oc_q == 2'd1) begin
        e0_q <= swmc_pkg::COST_W'(cost_full);
      end else begin
        e0_q <= e1_q;
        e1_q <= swmc_pkg::COST_W'(cost_full);
      end
    end else if (pop) begin
      e0_q <= e1_q;
    end else if (push) begin
      if (oc_q == 2'd0) begin
        e0_q <= swmc_pkg::COST_W'(cost_full);
      end else begin
        e1_q <= swmc_pkg::COST_W'(cost_full);
      end
    end
  end

`ifndef ASSERT_OFF
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= NW'(WINDOW_MAX - 1))
    else $error("fill count beyond window capacity");

  a_vld_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_q) == int'(fill_q))
    else $error("valid mask disagrees with fill count");

  a_msel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(msel_q))
    else $error("median marker not one-hot");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && emit) |=> out_valid_o)
    else $error("cost beat lost after full window");
`endif

endmodule

// ----- sim/sliding_window_median_cost_top_tb.sv -----
// ----------------------------------------------------------------------------
// sliding_window_median_cost_top_tb
// Self-checking bench for the sliding-window median cost block.
// ----------------------------------------------------------------------------
// Streams signed samples through the block under several window sizes. Sizes
// include zero, one, the largest window and values past it, and a size lowered
// while samples are still held. Each accepted sample feeds a local window
// model that keeps arrival order and sorted order. The model predicts the sum
// of absolute deviations from the lower median once the window is full. Cost
// beats are checked in order against those predictions. Both handshake sides
// stall at random, with one calm stretch on each side.
// ----------------------------------------------------------------------------
module sliding_window_median_cost_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WINDOW_MAX   = 64;
  localparam int unsigned SAMPLE_BITS  = 32;
  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned IDLE_PCT     = 13;

  localparam logic signed [31:0] SAMPLE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] SAMPLE_MAX = 32'sh7fff_ffff;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  swmc_pkg::win_size_t window_size_i = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic signed [31:0]  sample_i      = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  swmc_pkg::cost_t     cost_o;

  logic signed [31:0] sample_backlog[$];
  swmc_pkg::cost_t    cost_expected_q[$];

  longint      arrival_hist[WINDOW_MAX];
  longint      sorted_hist[WINDOW_MAX];
  int unsigned held_count    = 0;
  int unsigned arrival_ptr   = 0;
  int unsigned model_window  = 1;

  int unsigned samples_queued  = 0;
  int unsigned samples_taken   = 0;
  int unsigned costs_checked   = 0;
  int unsigned error_count     = 0;
  int unsigned cycle_count     = 0;

  sliding_window_median_cost_top #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .window_size_i(window_size_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cost_o       (cost_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned effective_window(input int unsigned w);
    if (w == 0) return 1;
    if (w > WINDOW_MAX) return WINDOW_MAX;
    return w;
  endfunction

  // Advance the window model by one sample; return 1 when a cost is due.
  function automatic bit predict_window_cost(input logic signed [31:0] s,
                                             output swmc_pkg::cost_t c);
    longint      v;
    longint      med;
    longint      acc;
    longint      leaving;
    int unsigned eff;
    int unsigned count;
    int unsigned oldest;
    int unsigned idx;
    v   = longint'(s);
    eff = effective_window(model_window);
    c   = '0;
    arrival_hist[arrival_ptr] = v;
    idx = held_count;
    while (idx > 0 && sorted_hist[idx-1] > v) begin
      sorted_hist[idx] = sorted_hist[idx-1];
      idx--;
    end
    sorted_hist[idx] = v;
    count       = held_count + 1;
    oldest      = (arrival_ptr + WINDOW_MAX - (count - 1)) % WINDOW_MAX;
    arrival_ptr = (arrival_ptr + 1) % WINDOW_MAX;
    if (count < eff) begin
      held_count = count;
      return 1'b0;
    end
    med = sorted_hist[(count + 1) / 2 - 1];
    acc = 0;
    for (int i = 0; i < count; i++) begin
      acc += (sorted_hist[i] > med) ? sorted_hist[i] - med : med - sorted_hist[i];
    end
    c = swmc_pkg::cost_t'(acc);
    // drop one copy of the oldest value
    leaving = arrival_hist[oldest];
    idx = 0;
    while (idx < count && sorted_hist[idx] != leaving) idx++;
    for (int j = idx; j + 1 < count; j++) begin
      sorted_hist[j] = sorted_hist[j+1];
    end
    held_count = count - 1;
    return 1'b1;
  endfunction

  function automatic logic signed [31:0] draw_sample(input logic [31:0] base);
    int unsigned mode;
    mode = $urandom_range(99);
    if (mode < 40) return $urandom;
    if (mode < 65) return 32'(int'($urandom_range(16)) - 8);
    if (mode < 80) begin
      case ($urandom_range(5))
        0:       return SAMPLE_MIN;
        1:       return SAMPLE_MAX;
        2:       return SAMPLE_MIN + 1;
        3:       return SAMPLE_MAX - 1;
        4:       return '0;
        default: return '1;
      endcase
    end
    return base + $urandom_range(255) - 128;
  endfunction

  task automatic queue_sample(input logic signed [31:0] s);
    sample_backlog = {sample_backlog, s};
    samples_queued++;
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (samples_taken != samples_queued || cost_expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(input swmc_pkg::win_size_t w);
    @(posedge clk_i);
    cfg_valid_i   <= 1'b1;
    window_size_i <= w;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    model_window = 32'(w);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_samples
    swmc_pkg::cost_t c;
    bit              calm;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      calm = samples_taken >= 300 && samples_taken < 520;
      if (in_valid_i && in_ready_o) begin
        if (predict_window_cost(sample_i, c)) cost_expected_q = {cost_expected_q, c};
        samples_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (sample_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid_i <= 1'b1;
          sample_i   <= sample_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_costs
    swmc_pkg::cost_t want;
    bit              calm;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (cost_expected_q.size() == 0) begin
          $display("%0t: unexpected cost beat, expected none, actual %0d", $time, cost_o);
          error_count++;
        end else begin
          want = cost_expected_q.pop_front();
          if (cost_o !== want) begin
            $display("%0t: cost mismatch, expected %0d, actual %0d", $time, want, cost_o);
            error_count++;
          end
        end
        costs_checked++;
      end
      calm = costs_checked >= 150 && costs_checked < 370;
      out_ready_i <= calm || $urandom_range(99) >= IDLE_PCT;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sliding_window_median_cost_top_tb: FAIL");
      $finish;
    end
  end

  initial begin : run_phases
    int unsigned fixed_windows[$];
    int unsigned random_sent;
    int unsigned w;
    int unsigned len;
    logic [31:0] base;
    fixed_windows = '{6, 8, 13, 21, 33, 48, 127, 1, 65, 0, 64, 100};
    random_sent   = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero window acts as one
    write_window(swmc_pkg::win_size_t'(0));
    queue_sample(SAMPLE_MAX);
    queue_sample(SAMPLE_MIN);
    drain();

    // extremes, then equal samples
    write_window(swmc_pkg::win_size_t'(5));
    queue_sample(SAMPLE_MIN);
    queue_sample(SAMPLE_MAX);
    queue_sample(SAMPLE_MIN);
    queue_sample(SAMPLE_MAX);
    queue_sample(SAMPLE_MAX);
    queue_sample(32'sd7);
    queue_sample(32'sd7);
    queue_sample(32'sd7);
    queue_sample(-32'sd1);
    queue_sample(32'sd0);
    drain();

    // window lowered while samples are held
    write_window(swmc_pkg::win_size_t'(2));
    queue_sample(32'sd3);
    queue_sample(32'sd1);
    queue_sample(32'sd2);
    queue_sample(32'sd4);
    drain();

    while (random_sent < RANDOM_ITEMS) begin
      w = (fixed_windows.size() != 0) ? fixed_windows.pop_front() : $urandom_range(127);
      write_window(swmc_pkg::win_size_t'(w));
      len = $urandom_range(30, 110);
      if (effective_window(w) > held_count) len += effective_window(w) - held_count;
      base = $urandom;
      repeat (len) queue_sample(draw_sample(base));
      random_sent += len;
      drain();
    end

    if (error_count == 0) begin
      $display("sliding_window_median_cost_top_tb: PASS");
    end else begin
      $display("sliding_window_median_cost_top_tb: FAIL");
    end
    $finish;
  end

endmodule
